[rtl/core/rpcard_pkg.sv]
// Shared constants, codes and types of the RPC application-ready detector.
package rpcard_pkg;

  localparam int MaxDatagram = 512;

  // header layout
  localparam int HdrLen     = 80;
  localparam int PosPktType = 1;
  localparam int PosUuidLo  = 8;
  localparam int PosUuidHi  = 24;
  localparam int PosSeqLo   = 64;
  localparam int PosSeqHi   = 68;
  localparam int PosOpHi    = 68;
  localparam int PosOpLo    = 69;

  localparam logic [7:0]  PtRequest  = 8'h00;
  localparam logic [15:0] OpControl  = 16'h0004;
  localparam logic [15:0] RdyBit     = 16'h0002;
  localparam logic [15:0] MinContent = 16'd26;
  localparam logic [15:0] CmdOfs     = 16'd22;
  localparam logic [15:0] BlkHdrLast = 16'd5;
  localparam logic [15:0] WantedTypeReset = 16'h0110;

  // walk phases
  localparam logic [1:0] PhHead    = 2'd0;
  localparam logic [1:0] PhContent = 2'd1;
  localparam logic [1:0] PhPad     = 2'd2;
  localparam logic [1:0] PhDone    = 2'd3;

  // verdict codes
  localparam logic [2:0] VerShort     = 3'd0;
  localparam logic [2:0] VerNotCtrl   = 3'd1;
  localparam logic [2:0] VerWrongObj  = 3'd2;
  localparam logic [2:0] VerNoBlock   = 3'd3;
  localparam logic [2:0] VerBlkShort  = 3'd4;
  localparam logic [2:0] VerNoReady   = 3'd5;
  localparam logic [2:0] VerReady     = 3'd6;

  // register indexes
  localparam logic [1:0] RegUuidHigh   = 2'd0;
  localparam logic [1:0] RegUuidLow    = 2'd1;
  localparam logic [1:0] RegWantedType = 2'd2;

  typedef struct packed {
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
    logic [15:0] wanted_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] ctrl_cmd;
    logic [31:0] seq_num;
  } result_t;

endpackage

[rtl/core/rpcard_if.sv]
// Valid/ready channel interfaces for datagram bytes and verdicts.
interface rpcard_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface rpcard_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [15:0] ctrl_cmd;
  logic [31:0] seq_num;
  modport source(output valid, output verdict, output ctrl_cmd,
                 output seq_num, input ready);
  modport sink(input valid, input verdict, input ctrl_cmd,
               input seq_num, output ready);
endinterface

[rtl/core/rpcard_cfg_regs.sv]
// APB-style configuration registers: AR UUID and wanted block type.
module rpcard_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output rpcard_pkg::cfg_t   cfg
);

  logic [63:0] uuid_high_r;
  logic [63:0] uuid_low_r;
  logic [15:0] wanted_type_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uuid_high_r   <= '0;
      uuid_low_r    <= '0;
      wanted_type_r <= rpcard_pkg::WantedTypeReset;
    end else if (wr_en) begin
      case (reg_idx)
        rpcard_pkg::RegUuidHigh:   uuid_high_r   <= pwdata;
        rpcard_pkg::RegUuidLow:    uuid_low_r    <= pwdata;
        rpcard_pkg::RegWantedType: wanted_type_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rpcard_pkg::RegUuidHigh:   prdata = uuid_high_r;
      rpcard_pkg::RegUuidLow:    prdata = uuid_low_r;
      rpcard_pkg::RegWantedType: prdata = {48'd0, wanted_type_r};
      default:                   prdata = '0;
    endcase
  end

  assign cfg.uuid_high   = uuid_high_r;
  assign cfg.uuid_low    = uuid_low_r;
  assign cfg.wanted_type = wanted_type_r;

endmodule

[rtl/core/rpcard_parser.sv]
// Per-byte header check and block walk; gives the verdict on the last byte.
module rpcard_parser #(
  parameter int MAX_DATAGRAM = rpcard_pkg::MaxDatagram
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rpcard_pkg::cfg_t      cfg,
  input  logic                  step,
  input  rpcard_pkg::byte_req_t req,
  output rpcard_pkg::result_t   res
);

  localparam int PosW = $clog2(MAX_DATAGRAM + 1);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [7:0]      ptype_r, ptype_nxt;
  logic [15:0]     op_r, op_nxt;
  logic            obj_ok_r, obj_ok_nxt;
  logic [31:0]     seq_r, seq_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [15:0]     wcnt_r, wcnt_nxt;
  logic [15:0]     kind_r, kind_nxt;
  logic [15:0]     size_r, size_nxt;
  logic            over_r, over_nxt;
  logic            matched_r, matched_nxt;
  logic [15:0]     mlen_r, mlen_nxt;
  logic [15:0]     cmd_r, cmd_nxt;

  logic [7:0]   b;
  logic [127:0] uuid;
  logic [3:0]   uidx;
  logic [7:0]   uuid_byte;
  logic [15:0]  wcnt_inc;
  logic [15:0]  size_adj;

  assign b         = req.data_byte;
  assign uuid      = {cfg.uuid_high, cfg.uuid_low};
  assign uidx      = 4'(pos_r - PosW'(rpcard_pkg::PosUuidLo));
  // byte 0 of the UUID sits in the top bits
  assign uuid_byte = uuid[{~uidx, 3'b000} +: 8];
  assign wcnt_inc  = wcnt_r + 16'd1;
  assign size_adj  = (size_r >= 16'd2) ? size_r - 16'd2 : 16'd0;

  always_comb begin
    pos_nxt     = pos_r;
    ptype_nxt   = ptype_r;
    op_nxt      = op_r;
    obj_ok_nxt  = obj_ok_r;
    seq_nxt     = seq_r;
    phase_nxt   = phase_r;
    wcnt_nxt    = wcnt_r;
    kind_nxt    = kind_r;
    size_nxt    = size_r;
    over_nxt    = over_r;
    matched_nxt = matched_r;
    mlen_nxt    = mlen_r;
    cmd_nxt     = cmd_r;
    res         = '0;

    if (step && (pos_r < PosW'(MAX_DATAGRAM))) begin
      pos_nxt = pos_r + PosW'(1);
      if (pos_r == PosW'(rpcard_pkg::PosPktType)) begin
        ptype_nxt = b;
      end else if (pos_r >= PosW'(rpcard_pkg::PosUuidLo) &&
                   pos_r <  PosW'(rpcard_pkg::PosUuidHi)) begin
        if (uuid_byte != b) obj_ok_nxt = 1'b0;
      end else if (pos_r >= PosW'(rpcard_pkg::PosSeqLo) &&
                   pos_r <  PosW'(rpcard_pkg::PosSeqHi)) begin
        seq_nxt = {seq_r[23:0], b};
      end else if (pos_r == PosW'(rpcard_pkg::PosOpHi) ||
                   pos_r == PosW'(rpcard_pkg::PosOpLo)) begin
        op_nxt = {op_r[7:0], b};
      end else if (pos_r >= PosW'(rpcard_pkg::HdrLen)) begin
        case (phase_r)
          rpcard_pkg::PhHead: begin
            case (wcnt_r)
              16'd0:   kind_nxt = {b, 8'h00};
              16'd1:   kind_nxt = {kind_r[15:8], b};
              16'd2:   size_nxt = {b, 8'h00};
              16'd3:   size_nxt = {size_r[15:8], b};
              default: ;
            endcase
            if (wcnt_r == rpcard_pkg::BlkHdrLast) begin
              size_nxt = size_adj;
              wcnt_nxt = 16'd0;
              if (kind_r == cfg.wanted_type) begin
                over_nxt = 1'b1;
                mlen_nxt = size_adj;
                cmd_nxt  = 16'd0;
                if (size_adj == 16'd0) begin
                  matched_nxt = 1'b1;
                  phase_nxt   = rpcard_pkg::PhDone;
                end else begin
                  phase_nxt = rpcard_pkg::PhContent;
                end
              end else begin
                phase_nxt = (size_adj == 16'd0) ? rpcard_pkg::PhHead
                                                : rpcard_pkg::PhContent;
              end
            end else begin
              wcnt_nxt = wcnt_inc;
            end
          end
          rpcard_pkg::PhContent: begin
            if (over_r) begin
              if (wcnt_r == rpcard_pkg::CmdOfs) cmd_nxt = {b, 8'h00};
              else if (wcnt_r == rpcard_pkg::CmdOfs + 16'd1) cmd_nxt = {cmd_r[15:8], b};
            end
            wcnt_nxt = wcnt_inc;
            if (wcnt_inc == size_r) begin
              wcnt_nxt = 16'd0;
              if (over_r) begin
                matched_nxt = 1'b1;
                phase_nxt   = rpcard_pkg::PhDone;
              end else begin
                phase_nxt = size_r[0] ? rpcard_pkg::PhPad : rpcard_pkg::PhHead;
              end
            end
          end
          rpcard_pkg::PhPad: begin
            phase_nxt = rpcard_pkg::PhHead;
            wcnt_nxt  = 16'd0;
          end
          default: ;
        endcase
      end
    end

    if (step && req.last_byte) begin
      res.seq_num = seq_nxt;
      if (pos_nxt < PosW'(rpcard_pkg::HdrLen)) begin
        res.verdict = rpcard_pkg::VerShort;
        res.seq_num = 32'd0;
      end else if (ptype_nxt != rpcard_pkg::PtRequest || op_nxt != rpcard_pkg::OpControl) begin
        res.verdict = rpcard_pkg::VerNotCtrl;
      end else if (!obj_ok_nxt) begin
        res.verdict = rpcard_pkg::VerWrongObj;
      end else if (!matched_nxt) begin
        res.verdict = rpcard_pkg::VerNoBlock;
      end else if (mlen_nxt < rpcard_pkg::MinContent) begin
        res.verdict = rpcard_pkg::VerBlkShort;
      end else begin
        res.ctrl_cmd = cmd_nxt;
        res.verdict = ((cmd_nxt & rpcard_pkg::RdyBit) != 16'd0) ? rpcard_pkg::VerReady
                                                                 : rpcard_pkg::VerNoReady;
      end
      // datagram done: back to the idle values
      pos_nxt     = '0;
      ptype_nxt   = '0;
      op_nxt      = '0;
      obj_ok_nxt  = 1'b1;
      seq_nxt     = '0;
      phase_nxt   = rpcard_pkg::PhHead;
      wcnt_nxt    = '0;
      kind_nxt    = '0;
      size_nxt    = '0;
      over_nxt    = 1'b0;
      matched_nxt = 1'b0;
      mlen_nxt    = '0;
      cmd_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      ptype_r   <= '0;
      op_r      <= '0;
      obj_ok_r  <= 1'b1;
      seq_r     <= '0;
      phase_r   <= rpcard_pkg::PhHead;
      wcnt_r    <= '0;
      kind_r    <= '0;
      size_r    <= '0;
      over_r    <= 1'b0;
      matched_r <= 1'b0;
      mlen_r    <= '0;
      cmd_r     <= '0;
    end else begin
      pos_r     <= pos_nxt;
      ptype_r   <= ptype_nxt;
      op_r      <= op_nxt;
      obj_ok_r  <= obj_ok_nxt;
      seq_r     <= seq_nxt;
      phase_r   <= phase_nxt;
      wcnt_r    <= wcnt_nxt;
      kind_r    <= kind_nxt;
      size_r    <= size_nxt;
      over_r    <= over_nxt;
      matched_r <= matched_nxt;
      mlen_r    <= mlen_nxt;
      cmd_r     <= cmd_nxt;
    end
  end

endmodule

[rtl/core/rpc_app_ready_detector.sv]
// Streams one datagram byte per cycle and reports whether it is an IODControl
// request for the configured AR that signals application ready. A byte is
// taken while the input register is free or advancing: it goes into the input
// register, the parser updates its header and block-walk state from it when
// that register advances, and on the last byte the verdict enters the output
// register at that advance. The sustained rate is one byte per cycle, set by
// the parser state update; only a verdict still waiting at the output holds a
// last byte back. Bytes beyond MAX_DATAGRAM are dropped, and no clearing pass
// is needed after reset.
module rpc_app_ready_detector #(
  parameter int MAX_DATAGRAM = rpcard_pkg::MaxDatagram
) (
  input  logic          clk,
  input  logic          rst_n,
  rpcard_in_if.sink     in_chan,
  rpcard_out_if.source  out_chan,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  rpcard_pkg::cfg_t      cfg;
  rpcard_pkg::byte_req_t in_req_r;
  rpcard_pkg::result_t   res;
  rpcard_pkg::result_t   out_res_r;
  logic                  in_valid_r;
  logic                  out_valid_r;
  logic                  advance;
  logic                  in_take;

  rpcard_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpcard_parser #(.MAX_DATAGRAM(MAX_DATAGRAM)) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (advance),
    .req   (in_req_r),
    .res   (res)
  );

  // a non-final byte never produces a result, so only a last byte waits
  assign advance        = in_valid_r && (!in_req_r.last_byte || !out_valid_r || out_chan.ready);
  assign in_chan.ready  = !in_valid_r || advance;
  assign in_take        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req_r.data_byte <= in_chan.data_byte;
      in_req_r.last_byte <= in_chan.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_req_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_req_r.last_byte) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.verdict  = out_res_r.verdict;
  assign out_chan.ctrl_cmd = out_res_r.ctrl_cmd;
  assign out_chan.seq_num  = out_res_r.seq_num;

endmodule

[bench/tb_rpc_app_ready_detector.sv]
// Self-checking bench for the RPC application-ready detector: random datagrams, APB setup.
`timescale 1ns / 100ps

module tb_rpc_app_ready_detector;

  localparam int StallLimit = 2000;
  localparam int IdlePct    = 23;

  // Tracks one datagram at a time and keeps the verdicts still due from the block.
  class verdict_tracker;
    logic [63:0] uuid_hi;
    logic [63:0] uuid_lo;
    logic [15:0] wanted_kind;
    int unsigned pos;
    logic [7:0]  pkt_type;
    logic [15:0] op_word;
    bit          obj_ok;
    logic [31:0] seq_word;
    logic [1:0]  phase;
    logic [15:0] cnt;
    logic [15:0] kind;
    logic [15:0] size;
    bit          found;
    bit          matched;
    logic [15:0] match_len;
    logic [15:0] cmd;
    rpcard_pkg::result_t due_verdicts[$];
    int          errors;

    function new();
      uuid_hi     = '0;
      uuid_lo     = '0;
      wanted_kind = rpcard_pkg::WantedTypeReset;
      errors      = 0;
      restart();
    endfunction

    function void restart();
      pos       = 0;
      pkt_type  = '0;
      op_word   = '0;
      obj_ok    = 1'b1;
      seq_word  = '0;
      phase     = rpcard_pkg::PhHead;
      cnt       = '0;
      kind      = '0;
      size      = '0;
      found     = 1'b0;
      matched   = 1'b0;
      match_len = '0;
      cmd       = '0;
    endfunction

    // block list walk: type, length, version, content, optional pad
    function void walk_block(logic [7:0] b);
      case (phase)
        rpcard_pkg::PhHead: begin
          case (cnt)
            0: kind[15:8] = b;
            1: kind[7:0]  = b;
            2: size[15:8] = b;
            3: size[7:0]  = b;
            default: ;
          endcase
          if (cnt == rpcard_pkg::BlkHdrLast) begin
            size = (size >= 16'd2) ? size - 16'd2 : 16'd0;
            cnt  = '0;
            if (kind == wanted_kind) begin
              found     = 1'b1;
              match_len = size;
              cmd       = '0;
              if (size == 16'd0) begin
                matched = 1'b1;
                phase   = rpcard_pkg::PhDone;
              end else begin
                phase = rpcard_pkg::PhContent;
              end
            end else begin
              phase = (size == 16'd0) ? rpcard_pkg::PhHead : rpcard_pkg::PhContent;
            end
          end else begin
            cnt++;
          end
        end
        rpcard_pkg::PhContent: begin
          if (found && cnt == rpcard_pkg::CmdOfs) cmd[15:8] = b;
          else if (found && cnt == rpcard_pkg::CmdOfs + 16'd1) cmd[7:0] = b;
          cnt++;
          if (cnt == size) begin
            cnt = '0;
            if (found) begin
              matched = 1'b1;
              phase   = rpcard_pkg::PhDone;
            end else begin
              phase = size[0] ? rpcard_pkg::PhPad : rpcard_pkg::PhHead;
            end
          end
        end
        rpcard_pkg::PhPad: begin
          phase = rpcard_pkg::PhHead;
          cnt   = '0;
        end
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int unsigned k;
      logic [63:0] word;
      rpcard_pkg::result_t r;
      if (pos < rpcard_pkg::MaxDatagram) begin
        if (pos == rpcard_pkg::PosPktType) begin
          pkt_type = b;
        end else if (pos >= rpcard_pkg::PosUuidLo && pos < rpcard_pkg::PosUuidHi) begin
          k    = pos - rpcard_pkg::PosUuidLo;
          word = (k < 8) ? uuid_hi : uuid_lo;
          if (word[63 - 8 * (k % 8) -: 8] != b) obj_ok = 1'b0;
        end else if (pos >= rpcard_pkg::PosSeqLo && pos < rpcard_pkg::PosSeqHi) begin
          seq_word = {seq_word[23:0], b};
        end else if (pos == rpcard_pkg::PosOpHi || pos == rpcard_pkg::PosOpLo) begin
          op_word = {op_word[7:0], b};
        end else if (pos >= rpcard_pkg::HdrLen) begin
          walk_block(b);
        end
        pos++;
      end
      if (last) begin
        r.ctrl_cmd = '0;
        r.seq_num  = seq_word;
        if (pos < rpcard_pkg::HdrLen) begin
          r.verdict = rpcard_pkg::VerShort;
          r.seq_num = '0;
        end else if (pkt_type != rpcard_pkg::PtRequest ||
                     op_word != rpcard_pkg::OpControl) begin
          r.verdict = rpcard_pkg::VerNotCtrl;
        end else if (!obj_ok) begin
          r.verdict = rpcard_pkg::VerWrongObj;
        end else if (!matched) begin
          r.verdict = rpcard_pkg::VerNoBlock;
        end else if (match_len < rpcard_pkg::MinContent) begin
          r.verdict = rpcard_pkg::VerBlkShort;
        end else begin
          r.ctrl_cmd = cmd;
          r.verdict  = ((cmd & rpcard_pkg::RdyBit) != 16'd0) ? rpcard_pkg::VerReady
                                                              : rpcard_pkg::VerNoReady;
        end
        due_verdicts.push_back(r);
        restart();
      end
    endfunction

    function void check_verdict(rpcard_pkg::result_t got);
      rpcard_pkg::result_t want;
      if (due_verdicts.size() == 0) begin
        $error("verdict %0d arrived with none due", got.verdict);
        errors++;
      end else begin
        want = due_verdicts.pop_front();
        if (got.verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
          errors++;
        end
        if (got.ctrl_cmd !== want.ctrl_cmd) begin
          $error("ctrl_cmd: expected %h, got %h", want.ctrl_cmd, got.ctrl_cmd);
          errors++;
        end
        if (got.seq_num !== want.seq_num) begin
          $error("seq_num: expected %h, got %h", want.seq_num, got.seq_num);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_fire;
  logic        out_fire;
  bit          steady;
  int          bytes_sent;
  logic [7:0]  dgram[$];

  verdict_tracker sb = new();

  rpcard_in_if  in_chan();
  rpcard_out_if out_chan();

  rpc_app_ready_detector uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  assign in_fire  = in_chan.valid & in_chan.ready;
  assign out_fire = out_chan.valid & out_chan.ready;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_fire) sb.note_byte(in_chan.data_byte, in_chan.last_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_fire)
      sb.check_verdict({out_chan.verdict, out_chan.ctrl_cmd, out_chan.seq_num});
    out_chan.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  initial begin : watchdog
    int quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [15:0] other_kind();
    logic [15:0] k;
    k = 16'($urandom);
    if (k == sb.wanted_kind) k = ~k;
    return k;
  endfunction

  function automatic logic [15:0] rand_cmd();
    logic [15:0] c;
    c = 16'($urandom);
    return $urandom_range(1) ? (c | rpcard_pkg::RdyBit) : (c & ~rpcard_pkg::RdyBit);
  endfunction

  function automatic void trim_to(int n);
    while (dgram.size() > n) void'(dgram.pop_back());
  endfunction

  function automatic void put_header(bit type_ok, bit op_ok, bit obj_ok);
    logic [15:0] op;
    logic [63:0] word;
    logic [7:0]  b;
    int          bad;
    op  = op_ok ? rpcard_pkg::OpControl
                : (rpcard_pkg::OpControl ^ (16'd1 << $urandom_range(15)));
    bad = $urandom_range(15);
    dgram.delete();
    for (int p = 0; p < rpcard_pkg::HdrLen; p++) begin
      b = 8'($urandom);
      if (p == rpcard_pkg::PosPktType) begin
        b = type_ok ? rpcard_pkg::PtRequest : 8'($urandom_range(255, 1));
      end else if (p >= rpcard_pkg::PosUuidLo && p < rpcard_pkg::PosUuidHi) begin
        word = (p - rpcard_pkg::PosUuidLo < 8) ? sb.uuid_hi : sb.uuid_lo;
        b = word[63 - 8 * ((p - rpcard_pkg::PosUuidLo) % 8) -: 8];
        if (!obj_ok && p - rpcard_pkg::PosUuidLo == bad) b = b ^ (8'd1 << $urandom_range(7));
      end else if (p == rpcard_pkg::PosOpHi) begin
        b = op[15:8];
      end else if (p == rpcard_pkg::PosOpLo) begin
        b = op[7:0];
      end
      dgram.push_back(b);
    end
  endfunction

  function automatic void put_block(logic [15:0] kind, logic [15:0] len_field,
                                    logic [15:0] cmd);
    int         body;
    logic [7:0] b;
    body = (len_field >= 16'd2) ? len_field - 2 : 0;
    dgram.push_back(kind[15:8]);
    dgram.push_back(kind[7:0]);
    dgram.push_back(len_field[15:8]);
    dgram.push_back(len_field[7:0]);
    dgram.push_back(8'($urandom));
    dgram.push_back(8'($urandom));
    for (int k = 0; k < body; k++) begin
      b = 8'($urandom);
      if (k == rpcard_pkg::CmdOfs) b = cmd[15:8];
      else if (k == rpcard_pkg::CmdOfs + 1) b = cmd[7:0];
      dgram.push_back(b);
    end
    if (body % 2) dgram.push_back(8'($urandom));
  endfunction

  function automatic void put_fillers(int n);
    for (int i = 0; i < n; i++)
      put_block(other_kind(), 16'($urandom_range(13)), 16'($urandom));
  endfunction

  // a random mix of well-formed requests and broken ones
  function automatic void make_random_dgram();
    int sel;
    int mark;
    int stop;
    sel = $urandom_range(99);
    if (sel < 5) begin
      put_header(1'b1, 1'b1, 1'b1);
      trim_to($urandom_range(rpcard_pkg::HdrLen - 1, 1));
    end else if (sel < 10) begin
      dgram.delete();
      repeat ($urandom_range(150, 80)) dgram.push_back(8'($urandom));
    end else begin
      put_header(!(sel inside {[10:14]}), !(sel inside {[15:19]}),
                 !(sel inside {[20:24]}));
      put_fillers($urandom_range(3));
      // wanted block pushed up against the length cap
      if (sel == 99) begin
        while (dgram.size() < rpcard_pkg::MaxDatagram - 30)
          put_block(other_kind(), 16'($urandom_range(13)), 16'h0000);
      end
      mark = dgram.size();
      if (sel inside {[25:34]})
        put_fillers($urandom_range(3, 1));
      else if (sel inside {[35:44]})
        put_block(sb.wanted_kind, 16'($urandom_range(rpcard_pkg::MinContent + 1)),
                  rand_cmd());
      else
        put_block(sb.wanted_kind, 16'($urandom_range(60, rpcard_pkg::MinContent + 2)),
                  rand_cmd());
      if (sel inside {[25:29], [45:54]}) begin
        trim_to($urandom_range(dgram.size() - 1, mark));
      end else if (sel >= 97) begin
        stop = rpcard_pkg::MaxDatagram + $urandom_range(30, 1);
        while (dgram.size() < stop) dgram.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(3)) dgram.push_back(8'($urandom));
      end
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last_byte <= last;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
  endtask

  task automatic send_dgram();
    for (int i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == dgram.size() - 1);
    bytes_sent += dgram.size();
  endtask

  // hold the sender until every verdict is back, then let the pipeline settle
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check(logic [1:0] idx, logic [63:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      $error("register %0d: expected %h, got %h", idx, want, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_cfg(logic [63:0] hi, logic [63:0] lo, logic [15:0] wanted);
    apb_write(rpcard_pkg::RegUuidHigh, hi);
    apb_write(rpcard_pkg::RegUuidLow, lo);
    apb_write(rpcard_pkg::RegWantedType, {48'd0, wanted});
    apb_check(rpcard_pkg::RegUuidHigh, hi);
    apb_check(rpcard_pkg::RegUuidLow, lo);
    apb_check(rpcard_pkg::RegWantedType, {48'd0, wanted});
    sb.uuid_hi     = hi;
    sb.uuid_lo     = lo;
    sb.wanted_kind = wanted;
  endtask

  initial begin : stimulus
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= '0;
    in_chan.last_byte <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    steady     = 1'b0;
    bytes_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: zero UUID, default block type
    put_header(1'b1, 1'b1, 1'b1);
    put_block(rpcard_pkg::WantedTypeReset, 16'd28, 16'hFFFF);
    send_dgram();
    wait_idle();
    write_cfg({$urandom, $urandom}, {$urandom, $urandom}, rpcard_pkg::WantedTypeReset);

    dgram = '{8'hFF};
    send_dgram();
    put_header(1'b1, 1'b1, 1'b1);
    trim_to(rpcard_pkg::HdrLen - 1);
    send_dgram();
    put_header(1'b1, 1'b1, 1'b1);
    send_dgram();
    put_header(1'b0, 1'b1, 1'b1);
    put_block(sb.wanted_kind, 16'd30, rpcard_pkg::RdyBit);
    send_dgram();
    put_header(1'b1, 1'b0, 1'b1);
    put_block(sb.wanted_kind, 16'd30, rpcard_pkg::RdyBit);
    send_dgram();
    put_header(1'b1, 1'b1, 1'b0);
    put_block(sb.wanted_kind, 16'd30, rpcard_pkg::RdyBit);
    send_dgram();
    put_header(1'b1, 1'b1, 1'b1);
    put_block(sb.wanted_kind, 16'd28, 16'hFFFF);
    send_dgram();
    put_header(1'b1, 1'b1, 1'b1);
    put_block(sb.wanted_kind, 16'd40, ~rpcard_pkg::RdyBit);
    send_dgram();
    put_header(1'b1, 1'b1, 1'b1);
    put_block(sb.wanted_kind, 16'd28, 16'h0000);
    send_dgram();
    // back to back with no idling on either side
    steady = 1'b1;
    // length fields below two mean empty content
    put_header(1'b1, 1'b1, 1'b1);
    put_block(sb.wanted_kind, 16'd0, 16'h0000);
    send_dgram();
    put_header(1'b1, 1'b1, 1'b1);
    put_block(sb.wanted_kind, 16'd1, 16'h0000);
    send_dgram();
    put_header(1'b1, 1'b1, 1'b1);
    put_block(sb.wanted_kind, 16'd27, 16'hFFFF);
    send_dgram();
    // odd filler content carries a pad byte
    put_header(1'b1, 1'b1, 1'b1);
    put_block(other_kind(), 16'd5, 16'h0000);
    put_block(sb.wanted_kind, 16'd29, rpcard_pkg::RdyBit);
    send_dgram();
    // filler cut off by the end of the datagram
    put_header(1'b1, 1'b1, 1'b1);
    put_block(other_kind(), 16'd200, 16'h0000);
    trim_to(rpcard_pkg::HdrLen + 50);
    send_dgram();
    // only the first wanted block counts
    put_header(1'b1, 1'b1, 1'b1);
    put_block(sb.wanted_kind, 16'd10, 16'h0000);
    put_block(sb.wanted_kind, 16'd28, 16'hFFFF);
    send_dgram();
    steady = 1'b0;
    // bytes past the cap are dropped, the last flag still closes the datagram
    put_header(1'b1, 1'b1, 1'b1);
    put_block(sb.wanted_kind, 16'd28, 16'hFFFF);
    while (dgram.size() < rpcard_pkg::MaxDatagram + 40) dgram.push_back(8'hFF);
    send_dgram();

    for (int n = 0; bytes_sent < 1300 || n < 8; n++) begin
      if (n % 2 == 0) begin
        wait_idle();
        case ((n / 2) % 4)
          0: write_cfg('1, '1, 16'hFFFF);
          1: write_cfg('0, '0, 16'h0000);
          2: write_cfg({$urandom, $urandom}, {$urandom, $urandom},
                       rpcard_pkg::WantedTypeReset);
          default: write_cfg({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
        endcase
      end
      make_random_dgram();
      send_dgram();
      if ($urandom_range(19) == 0) wait_idle();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.due_verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
